// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shorthand for clocked assertions sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Antecedent and consequent in the same cycle.
`define ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion check failed");

// Consequent in the cycle after the antecedent.
`define ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion check failed");

`endif

// ===== sv/mdsg_pkg.sv =====
// ----------------------------------------------------------------------------
// mdsg_pkg
// Shared widths, codes and types of the masked 2x2 downsample with gamma.
// ----------------------------------------------------------------------------
`default_nettype none

package mdsg_pkg;

	localparam int unsigned PIX_W          = 32;
	localparam int unsigned CH_W           = 8;
	localparam int unsigned SLOT_N         = PIX_W / CH_W;
	localparam int unsigned MAX_CHANNELS_C = 4;
	localparam int unsigned TABLE_DEPTH_C  = 1024;
	localparam int unsigned TBL_IDX_W      = $clog2(TABLE_DEPTH_C);
	localparam int unsigned QUAD_N         = 4;
	localparam int unsigned SUM_W          = CH_W + $clog2(QUAD_N);
	localparam int unsigned SCALE_SHIFT    = 2;
	localparam int unsigned CNT_W          = $clog2(QUAD_N + 1);
	localparam int unsigned CC_W           = 3;
	localparam int unsigned CFG_IDX_W      = 1;

	// Division by three as a multiply by 2731 / 8192, exact for the index range.
	localparam int unsigned DIV3_MUL       = 2731;
	localparam int unsigned DIV3_SHIFT     = 13;

	typedef enum logic {
		OP_LOAD  = 1'b0,
		OP_PIXEL = 1'b1
	} opcode_t;

	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_CHANNEL_COUNT = 1'b0,
		CFG_NODATA_PIXEL  = 1'b1
	} cfg_reg_t;

	typedef struct packed {
		logic                 adv1;
		logic                 adv2;
		logic                 adv3;
		logic                 tbl_we;
		logic [CNT_W-1:0]     cnt;
		logic [TBL_IDX_W-1:0] tbl_idx;
		logic [CH_W-1:0]      tbl_val;
	} lane_ctrl_t;

endpackage

`default_nettype wire

// ===== sv/mdsg_in_if.sv =====
// ----------------------------------------------------------------------------
// mdsg_in_if
// Input channel: table-load and pixel-quad items with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdsg_in_if
	import mdsg_pkg::*;
();

	logic                 valid;
	logic                 ready;
	logic                 opcode;
	logic [TBL_IDX_W-1:0] table_index;
	logic [CH_W-1:0]      table_value;
	logic [PIX_W-1:0]     pix_top_left;
	logic [PIX_W-1:0]     pix_top_right;
	logic [PIX_W-1:0]     pix_bottom_left;
	logic [PIX_W-1:0]     pix_bottom_right;
	logic [QUAD_N-1:0]    quad_valid;
	logic [PIX_W-1:0]     bg_pixel;
	logic                 bg_valid;

	modport source (
		output valid, opcode, table_index, table_value, pix_top_left, pix_top_right,
		       pix_bottom_left, pix_bottom_right, quad_valid, bg_pixel, bg_valid,
		input  ready
	);

	modport sink (
		input  valid, opcode, table_index, table_value, pix_top_left, pix_top_right,
		       pix_bottom_left, pix_bottom_right, quad_valid, bg_pixel, bg_valid,
		output ready
	);

endinterface

`default_nettype wire

// ===== sv/mdsg_out_if.sv =====
// ----------------------------------------------------------------------------
// mdsg_out_if
// Output channel: merged pixel items with valid/ready.
// ----------------------------------------------------------------------------
`default_nettype none

interface mdsg_out_if
	import mdsg_pkg::*;
();

	logic             valid;
	logic             ready;
	logic [PIX_W-1:0] out_pixel;
	logic             out_valid;

	modport source (
		output valid, out_pixel, out_valid,
		input  ready
	);

	modport sink (
		input  valid, out_pixel, out_valid,
		output ready
	);

endinterface

`default_nettype wire

// ===== sv/mdsg_lane.sv =====
// ----------------------------------------------------------------------------
// mdsg_lane
// One channel lane: masked quad sum, scaled average index, and a private
// copy of the gamma table with a registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module mdsg_lane
	import mdsg_pkg::*;
(
	input  wire logic                          clk,
	input  wire lane_ctrl_t                    ctrl,
	input  wire logic [QUAD_N-1:0][CH_W-1:0]   quad_bytes,
	input  wire logic [QUAD_N-1:0]             quad_valid,
	output logic      [CH_W-1:0]               rd_data
);

	localparam int unsigned SCL_W  = SUM_W + SCALE_SHIFT;
	localparam int unsigned MUL_W  = $clog2(DIV3_MUL + 1);
	localparam int unsigned PROD_W = SCL_W + MUL_W;

	logic [SUM_W-1:0]     sum_d;
	logic [SUM_W-1:0]     sum_s1;
	logic [SCL_W-1:0]     scaled;
	logic [PROD_W-1:0]    prod;
	logic [TBL_IDX_W-1:0] idx_d;
	logic [TBL_IDX_W-1:0] idx_s2;
	logic [CH_W-1:0]      rd_s3;
	logic [CH_W-1:0]      mem [TABLE_DEPTH_C];

	always_comb begin
		sum_d = '0;
		for (int k = 0; k < QUAD_N; k++) begin
			if (quad_valid[k]) begin
				sum_d = sum_d + SUM_W'(quad_bytes[k]);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv1) begin
			sum_s1 <= sum_d;
		end
	end

	assign scaled = {sum_s1, SCALE_SHIFT'(0)};
	assign prod   = PROD_W'(scaled) * PROD_W'(DIV3_MUL);

	always_comb begin
		case (ctrl.cnt)
			CNT_W'(2): idx_d = TBL_IDX_W'(scaled >> 1);
			CNT_W'(3): idx_d = TBL_IDX_W'(prod >> DIV3_SHIFT);
			CNT_W'(4): idx_d = TBL_IDX_W'(scaled >> 2);
			default:   idx_d = '0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (ctrl.adv2) begin
			idx_s2 <= idx_d;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.tbl_we) begin
			mem[ctrl.tbl_idx] <= ctrl.tbl_val;
		end
		if (ctrl.adv3) begin
			rd_s3 <= mem[idx_s2];
		end
	end

	assign rd_data = rd_s3;

endmodule

`default_nettype wire

// ===== sv/masked_2x2_downsample_gamma_top.sv =====
// A pixel item passes through the registered stages s1, s2 and s3 after it is accepted.
// Throughput: one item per cycle; a stalled output holds the last stage, and
// earlier stages still move forward into any empty stage ahead of them.
// Table-load items write the gamma table in the second stage and give no result.
// Reset clears the stage valid bits, channel count to one and nodata to zero;
// the gamma table is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// masked_2x2_downsample_gamma_top
// Three-stage pipeline that averages the valid pixels of a 2x2 quad per
// channel through a loadable gamma table, or passes the background or nodata pixel through.
// ----------------------------------------------------------------------------
`default_nettype none

module masked_2x2_downsample_gamma_top
	import mdsg_pkg::*;
#(
	parameter int unsigned MAX_CHANNELS = MAX_CHANNELS_C
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	mdsg_in_if.sink                   in_ch,
	mdsg_out_if.source                out_ch,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [PIX_W-1:0]     cfg_data
);

	logic [CC_W-1:0]   channel_count_q;
	logic [PIX_W-1:0]  nodata_q;

	logic              adv1;
	logic              adv2;
	logic              adv3;
	lane_ctrl_t        ctrl;

	logic [CC_W-1:0]   n_use;
	logic [SLOT_N-1:0] slot_en_d;
	logic [PIX_W-1:0]  bg_src;
	logic [PIX_W-1:0]  bypass_d;
	logic [CNT_W-1:0]  cnt_d;

	logic                 v_s1;
	logic                 v_s2;
	logic                 v_s3;
	logic                 op_s1;
	logic                 op_s2;
	logic [TBL_IDX_W-1:0] tidx_s1;
	logic [TBL_IDX_W-1:0] tidx_s2;
	logic [CH_W-1:0]      tval_s1;
	logic [CH_W-1:0]      tval_s2;
	logic [CNT_W-1:0]     cnt_s1;
	logic                 avg_s1;
	logic                 avg_s2;
	logic                 avg_s3;
	logic                 bgok_s1;
	logic                 bgok_s2;
	logic                 bgok_s3;
	logic [PIX_W-1:0]     bypass_s1;
	logic [PIX_W-1:0]     bypass_s2;
	logic [PIX_W-1:0]     bypass_s3;
	logic [SLOT_N-1:0]    slot_en_s1;
	logic [SLOT_N-1:0]    slot_en_s2;
	logic [SLOT_N-1:0]    slot_en_s3;

	logic [MAX_CHANNELS-1:0][CH_W-1:0] rd_s3;
	logic [PIX_W-1:0]                  gamma_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			channel_count_q <= CC_W'(1);
			nodata_q        <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CHANNEL_COUNT: channel_count_q <= cfg_data[CC_W-1:0];
				CFG_NODATA_PIXEL:  nodata_q        <= cfg_data;
				default:           ;
			endcase
		end
	end

	assign adv3        = !v_s3 || out_ch.ready;
	assign adv2        = !v_s2 || adv3;
	assign adv1        = !v_s1 || adv2;
	assign in_ch.ready = adv1;

	always_comb begin
		if (channel_count_q == '0) begin
			n_use = CC_W'(1);
		end else if (channel_count_q > CC_W'(MAX_CHANNELS)) begin
			n_use = CC_W'(MAX_CHANNELS);
		end else begin
			n_use = channel_count_q;
		end
		for (int c = 0; c < SLOT_N; c++) begin
			slot_en_d[c] = (CC_W'(c) < n_use);
		end
	end

	assign bg_src = in_ch.bg_valid ? in_ch.bg_pixel : nodata_q;
	assign cnt_d  = CNT_W'($countones(in_ch.quad_valid));

	always_comb begin
		for (int c = 0; c < SLOT_N; c++) begin
			bypass_d[c*CH_W +: CH_W] = slot_en_d[c] ? bg_src[c*CH_W +: CH_W] : '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			if (adv1) begin
				v_s1 <= in_ch.valid;
			end
			if (adv2) begin
				v_s2 <= v_s1;
			end
			if (adv3) begin
				v_s3 <= v_s2 && (op_s2 == OP_PIXEL);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv1) begin
			op_s1      <= in_ch.opcode;
			tidx_s1    <= in_ch.table_index;
			tval_s1    <= in_ch.table_value;
			cnt_s1     <= cnt_d;
			avg_s1     <= (cnt_d >= CNT_W'(2));
			bgok_s1    <= in_ch.bg_valid;
			bypass_s1  <= bypass_d;
			slot_en_s1 <= slot_en_d;
		end
		if (adv2) begin
			op_s2      <= op_s1;
			tidx_s2    <= tidx_s1;
			tval_s2    <= tval_s1;
			avg_s2     <= avg_s1;
			bgok_s2    <= bgok_s1;
			bypass_s2  <= bypass_s1;
			slot_en_s2 <= slot_en_s1;
		end
		if (adv3) begin
			avg_s3     <= avg_s2;
			bgok_s3    <= bgok_s2;
			bypass_s3  <= bypass_s2;
			slot_en_s3 <= slot_en_s2;
		end
	end

	always_comb begin
		ctrl         = '0;
		ctrl.adv1    = adv1;
		ctrl.adv2    = adv2;
		ctrl.adv3    = adv3;
		ctrl.tbl_we  = v_s2 && (op_s2 == OP_LOAD) && adv3;
		ctrl.cnt     = cnt_s1;
		ctrl.tbl_idx = tidx_s2;
		ctrl.tbl_val = tval_s2;
	end

	for (genvar l = 0; l < MAX_CHANNELS; l++) begin : g_lane
		mdsg_lane u_lane (
			.clk        (clk),
			.ctrl       (ctrl),
			.quad_bytes ({in_ch.pix_bottom_right[l*CH_W +: CH_W],
			              in_ch.pix_bottom_left[l*CH_W +: CH_W],
			              in_ch.pix_top_right[l*CH_W +: CH_W],
			              in_ch.pix_top_left[l*CH_W +: CH_W]}),
			.quad_valid (in_ch.quad_valid),
			.rd_data    (rd_s3[l])
		);
		assign gamma_pix[l*CH_W +: CH_W] = slot_en_s3[l] ? rd_s3[l] : '0;
	end

	if (MAX_CHANNELS < SLOT_N) begin : g_pad
		assign gamma_pix[PIX_W-1:MAX_CHANNELS*CH_W] = '0;
	end

	assign out_ch.valid     = v_s3;
	assign out_ch.out_pixel = avg_s3 ? gamma_pix : bypass_s3;
	assign out_ch.out_valid = avg_s3 || bgok_s3;

endmodule

`default_nettype wire

// ===== sv/mdsg_checker.sv =====
// ----------------------------------------------------------------------------
// mdsg_checker
// Port-level checks of the downsample pipeline, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module mdsg_checker
	import mdsg_pkg::*;
(
	input wire logic             clk,
	input wire logic             arst_n,
	input wire logic             in_valid,
	input wire logic             in_ready,
	input wire logic             in_opcode,
	input wire logic             out_valid,
	input wire logic             out_ready,
	input wire logic [PIX_W-1:0] out_pixel,
	input wire logic             out_mask
);

	// The input side only waits when the output holds an item nobody takes.
	`ASSERT_IMP(a_in_stall_cause, !in_ready, out_valid && !out_ready)

	// With the output ready on the cycles between, an accepted pixel item reaches the output.
	`ASSERT_NXT(a_pixel_latency,
		(in_valid && in_ready && (in_opcode == OP_PIXEL)) ##1 out_ready ##1 out_ready,
		out_valid)

	`ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid)

	`ASSERT_NXT(a_out_stable, out_valid && !out_ready,
		$stable(out_pixel) && $stable(out_mask))

endmodule

bind masked_2x2_downsample_gamma_top mdsg_checker u_mdsg_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_ch.valid),
	.in_ready  (in_ch.ready),
	.in_opcode (in_ch.opcode),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.out_pixel (out_ch.out_pixel),
	.out_mask  (out_ch.out_valid)
);

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the masked 2x2 downsample with gamma lookup. A short
// table of directed items runs first, then random phases under several
// channel counts and nodata values, with idle and stall patterns on both sides.
// Every output item is checked against a predictor kept inside the bench or a fixed expected value.
// ----------------------------------------------------------------------------

module tb_top;
	import mdsg_pkg::*;

	localparam int unsigned CYCLE_LIMIT     = 400000;
	localparam int unsigned DRAIN_CYCLES    = 8;
	localparam int unsigned PHASES          = 8;
	localparam int unsigned ITEMS_PER_PHASE = 85;
	localparam int unsigned HOLD_CYCLES     = 80;

	typedef struct {
		opcode_t                       op;
		logic [TBL_IDX_W-1:0]          tidx;
		logic [CH_W-1:0]               tval;
		logic [QUAD_N-1:0][PIX_W-1:0]  quad;
		logic [QUAD_N-1:0]             qv;
		logic [PIX_W-1:0]              bg;
		logic                          bgv;
	} quad_item_t;

	typedef struct packed {
		logic [PIX_W-1:0] pix;
		logic             v;
	} pix_result_t;

	typedef struct {
		quad_item_t  item;
		bit          fixed;
		pix_result_t want;
	} directed_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [PIX_W-1:0]     cfg_data;

	mdsg_in_if  in_ch();
	mdsg_out_if out_ch();

	masked_2x2_downsample_gamma_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	logic [CH_W-1:0]  gamma_copy [TABLE_DEPTH_C];
	bit               entry_written [TABLE_DEPTH_C];
	logic [CC_W-1:0]  cc_copy;
	logic [PIX_W-1:0] nodata_copy;
	pix_result_t      merged_q [$];
	directed_row_t    dir_rows [$];

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;
	int unsigned hold_requests;
	int unsigned hold_seen;
	int unsigned hold_left;
	int unsigned cycles;
	int unsigned errors;
	int unsigned n_loads;
	int unsigned n_pixels;
	int unsigned n_results;
	int unsigned n_settings;

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	function automatic int unsigned lanes_of(logic [CC_W-1:0] cc);
		if (cc == '0) return 1;
		if (cc > MAX_CHANNELS_C) return MAX_CHANNELS_C;
		return int'(cc);
	endfunction

	function automatic int unsigned lane_index(quad_item_t it, int unsigned c);
		int unsigned total;
		total = 0;
		for (int k = 0; k < QUAD_N; k++)
			if (it.qv[k]) total += it.quad[k][c*CH_W +: CH_W];
		return (total << SCALE_SHIFT) / $countones(it.qv);
	endfunction

	function automatic pix_result_t merge_quad(quad_item_t it);
		pix_result_t r;
		int unsigned n;
		n = lanes_of(cc_copy);
		r.pix = '0;
		if ($countones(it.qv) >= 2) begin
			for (int c = 0; c < n; c++)
				r.pix[c*CH_W +: CH_W] = gamma_copy[lane_index(it, c)];
			r.v = 1'b1;
		end else begin
			r.pix = it.bgv ? it.bg : nodata_copy;
			for (int c = n; c < SLOT_N; c++)
				r.pix[c*CH_W +: CH_W] = '0;
			r.v = it.bgv;
		end
		return r;
	endfunction

	function automatic void absorb(quad_item_t it, bit fixed, pix_result_t want);
		if (it.op == OP_LOAD) begin
			gamma_copy[it.tidx] = it.tval;
			entry_written[it.tidx] = 1'b1;
			n_loads++;
		end else begin
			merged_q.push_back(fixed ? want : merge_quad(it));
			n_pixels++;
		end
	endfunction

	function automatic logic [PIX_W-1:0] rand_pix();
		logic [PIX_W-1:0] p;
		p = $urandom();
		case ($urandom_range(0, 3))
			1: p = '0;
			2: p = '1;
			3: begin
				for (int c = 0; c < SLOT_N; c++)
					if ($urandom_range(0, 2) == 0) p[c*CH_W +: CH_W] = '0;
					else if ($urandom_range(0, 1) == 0) p[c*CH_W +: CH_W] = '1;
			end
			default: ;
		endcase
		return p;
	endfunction

	function automatic quad_item_t mk_pix(logic [PIX_W-1:0] tl, logic [PIX_W-1:0] tr,
			logic [PIX_W-1:0] bl, logic [PIX_W-1:0] br, logic [QUAD_N-1:0] qv,
			logic [PIX_W-1:0] bg, logic bgv);
		quad_item_t it;
		it.op = OP_PIXEL;
		it.tidx = TBL_IDX_W'($urandom_range(0, TABLE_DEPTH_C - 1));
		it.tval = CH_W'($urandom_range(0, 255));
		it.quad[0] = tl;
		it.quad[1] = tr;
		it.quad[2] = bl;
		it.quad[3] = br;
		it.qv = qv;
		it.bg = bg;
		it.bgv = bgv;
		return it;
	endfunction

	function automatic quad_item_t mk_load(logic [TBL_IDX_W-1:0] idx, logic [CH_W-1:0] val);
		quad_item_t it;
		it = mk_pix($urandom(), $urandom(), $urandom(), $urandom(),
			QUAD_N'($urandom_range(0, 15)), $urandom(), 1'($urandom_range(0, 1)));
		it.op = OP_LOAD;
		it.tidx = idx;
		it.tval = val;
		return it;
	endfunction

	function automatic void add_row(quad_item_t it, bit fixed, logic [PIX_W-1:0] pix,
			logic v);
		directed_row_t row;
		row.item = it;
		row.fixed = fixed;
		row.want.pix = pix;
		row.want.v = v;
		dir_rows.push_back(row);
	endfunction

	task automatic issue(quad_item_t it, bit fixed, pix_result_t want);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_ch.valid <= 1'b0;
			@(posedge clk);
		end
		in_ch.valid            <= 1'b1;
		in_ch.opcode           <= it.op;
		in_ch.table_index      <= it.tidx;
		in_ch.table_value      <= it.tval;
		in_ch.pix_top_left     <= it.quad[0];
		in_ch.pix_top_right    <= it.quad[1];
		in_ch.pix_bottom_left  <= it.quad[2];
		in_ch.pix_bottom_right <= it.quad[3];
		in_ch.quad_valid       <= it.qv;
		in_ch.bg_pixel         <= it.bg;
		in_ch.bg_valid         <= it.bgv;
		do @(posedge clk); while (!in_ch.ready);
		absorb(it, fixed, want);
	endtask

	// Entries never loaded must not be read, so a quad that would read one is
	// preceded by a load of that entry.
	task automatic send_quad(quad_item_t it, bit fixed, pix_result_t want);
		int unsigned idx;
		pix_result_t none;
		none = '0;
		if (it.op == OP_PIXEL && $countones(it.qv) >= 2) begin
			for (int c = 0; c < lanes_of(cc_copy); c++) begin
				idx = lane_index(it, c);
				if (!entry_written[idx])
					issue(mk_load(TBL_IDX_W'(idx), CH_W'($urandom_range(0, 255))),
						1'b0, none);
			end
		end
		issue(it, fixed, want);
	endtask

	task automatic settle();
		in_ch.valid <= 1'b0;
		@(posedge clk);
		while (merged_q.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apply_settings(logic [PIX_W-1:0] cc_word, logic [PIX_W-1:0] nd_word);
		cfg_we    <= 1'b1;
		cfg_index <= CFG_CHANNEL_COUNT;
		cfg_data  <= cc_word;
		@(posedge clk);
		cfg_index <= CFG_NODATA_PIXEL;
		cfg_data  <= nd_word;
		@(posedge clk);
		cfg_we <= 1'b0;
		cc_copy = cc_word[CC_W-1:0];
		nodata_copy = nd_word;
		n_settings++;
	endtask

	always @(posedge clk) begin
		if (hold_seen != hold_requests) begin
			hold_seen = hold_requests;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			out_ch.ready <= 1'b0;
		end else begin
			out_ch.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		pix_result_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			n_results++;
			if (merged_q.size() == 0) begin
				errors++;
				$error("unexpected item: out_pixel %h out_valid %b",
					out_ch.out_pixel, out_ch.out_valid);
			end else begin
				want = merged_q.pop_front();
				if (out_ch.out_pixel !== want.pix) begin
					errors++;
					$error("out_pixel: expected %h, actual %h", want.pix, out_ch.out_pixel);
				end
				if (out_ch.out_valid !== want.v) begin
					errors++;
					$error("out_valid: expected %b, actual %b", want.v, out_ch.out_valid);
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d items still expected.",
				cycles, merged_q.size());
			$display("Simulation FAILED");
			$finish;
		end
	end

	initial begin
		quad_item_t       it;
		pix_result_t      none;
		logic [CC_W-1:0]  cc_list [PHASES];
		logic [PIX_W-1:0] cc_word;
		logic [PIX_W-1:0] nd_word;
		int unsigned      phase_end;

		arst_n                 = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = CFG_CHANNEL_COUNT;
		cfg_data               = '0;
		in_ch.valid            = 1'b0;
		in_ch.opcode           = OP_LOAD;
		in_ch.table_index      = '0;
		in_ch.table_value      = '0;
		in_ch.pix_top_left     = '0;
		in_ch.pix_top_right    = '0;
		in_ch.pix_bottom_left  = '0;
		in_ch.pix_bottom_right = '0;
		in_ch.quad_valid       = '0;
		in_ch.bg_pixel         = '0;
		in_ch.bg_valid         = 1'b0;
		send_idle_pct  = 0;
		recv_stall_pct = 0;
		hold_requests  = 0;
		n_loads        = 0;
		n_pixels       = 0;
		n_settings     = 0;
		cc_copy        = CC_W'(1);
		nodata_copy    = '0;
		none           = '0;
		for (int i = 0; i < TABLE_DEPTH_C; i++) begin
			gamma_copy[i] = '0;
			entry_written[i] = 1'b0;
		end
		cc_list = '{3'd4, 3'd2, 3'd3, 3'd0, 3'd7, 3'd5, 3'd1, 3'd6};

		// Reset settings: one channel, nodata zero, table still empty.
		add_row(mk_pix('1, '1, '1, '1, 4'b0000, 32'hDEADBEEF, 1'b0), 1, 32'h0, 1'b0);
		add_row(mk_pix('0, '0, '0, '0, 4'b0001, 32'hFFFFFFFF, 1'b1), 1, 32'hFF, 1'b1);
		add_row(mk_pix('1, '1, '1, '1, 4'b1000, 32'h12345678, 1'b0), 1, 32'h0, 1'b0);
		add_row(mk_load(10'd0, 8'h11), 0, '0, 1'b0);
		add_row(mk_load(10'd1020, 8'hFF), 0, '0, 1'b0);
		add_row(mk_load(10'd1023, 8'hA5), 0, '0, 1'b0);
		add_row(mk_load(10'd1021, 8'h3C), 0, '0, 1'b0);
		it = mk_pix('0, '0, '0, '0, 4'b1111, '0, 1'b0);
		it.tidx = '1;
		it.tval = '1;
		add_row(it, 1, 32'h11, 1'b1);
		add_row(mk_pix('1, '1, '1, '1, 4'b1111, '0, 1'b0), 1, 32'hFF, 1'b1);
		add_row(mk_pix('1, '1, '0, '0, 4'b0011, '0, 1'b1), 1, 32'hFF, 1'b1);
		add_row(mk_pix('1, '1, '1, '0, 4'b0111, '0, 1'b0), 1, 32'hFF, 1'b1);
		add_row(mk_pix('0, '1, '1, '0, 4'b1001, '1, 1'b1), 1, 32'h11, 1'b1);
		add_row(mk_pix(rand_pix(), rand_pix(), rand_pix(), rand_pix(), 4'b1110,
			$urandom(), 1'b0), 0, '0, 1'b0);
		it = mk_load(10'd512, 8'h80);
		it.quad = '1;
		it.qv = '1;
		it.bg = '1;
		it.bgv = 1'b1;
		add_row(it, 0, '0, 1'b0);
		add_row(mk_pix(32'h00000080, '1, 32'h00000080, '1, 4'b0101, '0, 1'b0), 1,
			32'h80, 1'b1);
		add_row(mk_pix('0, 32'h01, '0, '0, 4'b0110, '0, 1'b0), 0, '0, 1'b0);
		add_row(mk_pix(32'h01, 32'h01, '0, 32'h01, 4'b1011, '0, 1'b0), 0, '0, 1'b0);
		add_row(mk_pix('1, '1, '1, '1, 4'b0001, 32'h12345678, 1'b1), 1, 32'h78, 1'b1);
		add_row(mk_load(10'd1022, 8'hFF), 0, '0, 1'b0);
		add_row(mk_pix('1, '1, '1, '1, 4'b0100, '1, 1'b0), 1, 32'h0, 1'b0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_quad(dir_rows[i].item, dir_rows[i].fixed, dir_rows[i].want);
		settle();

		for (int p = 0; p < PHASES; p++) begin
			case (p % 4)
				0: begin
					send_idle_pct = 0;
					recv_stall_pct <= 0;
				end
				1: begin
					send_idle_pct = 51;
					recv_stall_pct <= 0;
				end
				2: begin
					send_idle_pct = 0;
					recv_stall_pct <= 51;
				end
				default: begin
					send_idle_pct = 31;
					recv_stall_pct <= 31;
				end
			endcase
			cc_word = $urandom();
			cc_word[CC_W-1:0] = cc_list[p];
			if (p == 0) nd_word = '1;
			else if (p == 3) nd_word = '0;
			else nd_word = $urandom();
			apply_settings(cc_word, nd_word);
			phase_end = n_loads + n_pixels + ITEMS_PER_PHASE;
			for (int i = 0; n_loads + n_pixels < phase_end; i++) begin
				if (p == 0 && i == 5) hold_requests <= hold_requests + 1;
				if (p == 5 && i == 10) settle();
				if ($urandom_range(0, 99) < 25)
					it = mk_load(TBL_IDX_W'($urandom_range(0, TABLE_DEPTH_C - 1)),
						CH_W'($urandom_range(0, 255)));
				else
					it = mk_pix(rand_pix(), rand_pix(), rand_pix(), rand_pix(),
						QUAD_N'($urandom_range(0, 15)), rand_pix(),
						1'($urandom_range(0, 1)));
				send_quad(it, 1'b0, none);
			end
			settle();
		end

		$display("Covered %0d pixel items and %0d table loads under %0d register settings.",
			n_pixels, n_loads, n_settings);
		$display("Checked %0d output items with %0d mismatches.", n_results, errors);
		if (errors == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule
